// ===== rtl/core/image_header_size_parser_macros.svh =====
// Assertion macros shared by the image header size parser modules.
`ifndef IMAGE_HEADER_SIZE_PARSER_MACROS_SVH
`define IMAGE_HEADER_SIZE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define IHSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== rtl/core/ihsp_pkg.sv =====
// Shared types, constants and helper functions for the image header size parser.
package ihsp_pkg;

	localparam int HDR_LEN = 24;
	localparam int WIN_LEN = 12;

	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] BYTE_SOI = 8'hD8;
	localparam logic [7:0] BYTE_APP0 = 8'hE0;
	localparam logic [7:0] BYTE_PNG0 = 8'h89;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_SUB = 8'h1A;

	localparam logic [1:0] FMT_UNKNOWN = 2'd0;
	localparam logic [1:0] FMT_JPEG    = 2'd1;
	localparam logic [1:0] FMT_GIF     = 2'd2;
	localparam logic [1:0] FMT_PNG     = 2'd3;

	typedef logic [WIN_LEN-1:0][7:0] win_t;

	// Summary of the first 24 bytes, including the byte being processed.
	typedef struct packed {
		logic        full;
		logic        soi;
		logic        jfif;
		logic        gif;
		logic        png;
		logic [31:0] gif_width;
		logic [31:0] gif_height;
		logic [31:0] png_width;
		logic [31:0] png_height;
	} hdr_info_t;

	// Start-of-frame markers that carry the frame size.
	function automatic logic is_sof(input logic [7:0] m);
		return m == 8'hC0 || m == 8'hC1 || m == 8'hC2 || m == 8'hC3 ||
			m == 8'hC9 || m == 8'hCA || m == 8'hCB;
	endfunction

endpackage

// ===== rtl/core/ihsp_hdr_store.sv =====
// Header byte store for the first 24 file bytes and its format signature checks.
module ihsp_hdr_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  last,
	input  logic [7:0]            data,
	output logic [4:0]            idx,
	output ihsp_pkg::hdr_info_t   info
);

	localparam logic [4:0] HDR_FULL = 5'(ihsp_pkg::HDR_LEN);

	logic [ihsp_pkg::HDR_LEN-1:0][7:0] hdr_q;
	logic [ihsp_pkg::HDR_LEN-1:0][7:0] hdr_d;
	logic [4:0]                        count_q;
	logic [4:0]                        count_d;

	assign idx = count_q;

	// The current byte is merged in so that decisions see it in the same cycle.
	always_comb begin
		hdr_d = hdr_q;
		for (int i = 0; i < ihsp_pkg::HDR_LEN; i++) begin
			if (count_q == 5'(i)) begin
				hdr_d[i] = data;
			end
		end
		count_d = (count_q < HDR_FULL) ? count_q + 5'd1 : count_q;
	end

	always_comb begin
		info.full = count_d >= HDR_FULL;
		info.soi  = hdr_d[0] == ihsp_pkg::BYTE_FF && hdr_d[1] == ihsp_pkg::BYTE_SOI;
		info.jfif = info.soi && hdr_d[2] == ihsp_pkg::BYTE_FF &&
			hdr_d[3] == ihsp_pkg::BYTE_APP0 && hdr_d[6] == "J" && hdr_d[7] == "F" &&
			hdr_d[8] == "I" && hdr_d[9] == "F";
		info.gif  = hdr_d[0] == "G" && hdr_d[1] == "I" && hdr_d[2] == "F";
		info.png  = hdr_d[0] == ihsp_pkg::BYTE_PNG0 && hdr_d[1] == "P" &&
			hdr_d[2] == "N" && hdr_d[3] == "G" && hdr_d[4] == ihsp_pkg::BYTE_CR &&
			hdr_d[5] == ihsp_pkg::BYTE_LF && hdr_d[6] == ihsp_pkg::BYTE_SUB &&
			hdr_d[7] == ihsp_pkg::BYTE_LF && hdr_d[12] == "I" && hdr_d[13] == "H" &&
			hdr_d[14] == "D" && hdr_d[15] == "R";
		info.gif_width  = {16'd0, hdr_d[7], hdr_d[6]};
		info.gif_height = {16'd0, hdr_d[9], hdr_d[8]};
		info.png_width  = {hdr_d[16], hdr_d[17], hdr_d[18], hdr_d[19]};
		info.png_height = {hdr_d[20], hdr_d[21], hdr_d[22], hdr_d[23]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= last ? 5'd0 : count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			hdr_q <= hdr_d;
		end
	end

endmodule

// ===== rtl/core/ihsp_seg_walker.sv =====
// JPEG segment walker: fills the 12-byte window, follows marker lengths, keeps the last window.
`include "image_header_size_parser_macros.svh"

module ihsp_seg_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                last,
	input  logic [7:0]          data,
	input  logic [4:0]          idx,
	input  logic                jfif,
	output ihsp_pkg::win_t      kept
);

	typedef enum logic [1:0] {PH_INIT, PH_FILL, PH_SKIP, PH_DONE} phase_t;

	localparam logic [4:0]  WIN_START = 5'd2;
	localparam logic [4:0]  WIN_END   = 5'(ihsp_pkg::WIN_LEN + 1);
	localparam logic [3:0]  WIN_FULL  = 4'(ihsp_pkg::WIN_LEN);
	localparam logic [16:0] WIN_LEN17 = 17'(ihsp_pkg::WIN_LEN);

	phase_t         phase_q, phase_d;
	logic [3:0]     fill_q, fill_d;
	logic [16:0]    skip_q, skip_d;
	ihsp_pkg::win_t win_q, win_d, kept_q, kept_d, shifted;
	logic [16:0]    seg_len;
	logic           do_walk;

	assign kept = kept_d;

	always_comb begin
		win_d   = win_q;
		kept_d  = kept_q;
		phase_d = phase_q;
		fill_d  = fill_q;
		skip_d  = skip_q;
		do_walk = 1'b0;
		seg_len = '0;
		shifted = '0;
		unique case (phase_q)
			PH_INIT: begin
				if (idx >= WIN_START && idx <= WIN_END) begin
					win_d[4'(idx - WIN_START)] = data;
				end
				if (idx >= WIN_END) begin
					kept_d = win_d;
					if (jfif) begin
						do_walk = 1'b1;
					end else begin
						phase_d = PH_DONE;
					end
				end
			end
			PH_FILL: begin
				win_d[fill_q] = data;
				fill_d = fill_q + 4'd1;
				if (fill_d >= WIN_FULL) begin
					kept_d  = win_d;
					do_walk = 1'b1;
				end
			end
			PH_SKIP: begin
				if (skip_q != '0) begin
					skip_d = skip_q - 17'd1;
				end
				if (skip_d == '0) begin
					fill_d  = '0;
					phase_d = PH_FILL;
				end
			end
			PH_DONE: begin
			end
		endcase

		// A complete window decides where the next one starts.
		if (do_walk) begin
			if (win_d[0] != ihsp_pkg::BYTE_FF || ihsp_pkg::is_sof(win_d[1])) begin
				phase_d = PH_DONE;
			end else begin
				seg_len = {1'b0, win_d[2], win_d[3]} + 17'd2;
				if (seg_len < WIN_LEN17) begin
					shifted = win_d >> {seg_len[3:0], 3'b000};
					win_d   = shifted;
					fill_d  = WIN_FULL - seg_len[3:0];
					phase_d = PH_FILL;
				end else begin
					fill_d  = '0;
					skip_d  = seg_len - WIN_LEN17;
					phase_d = (skip_d == '0) ? PH_FILL : PH_SKIP;
				end
			end
		end

		if (last) begin
			phase_d = PH_INIT;
			fill_d  = '0;
			skip_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT;
			fill_q  <= '0;
			skip_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
			skip_q  <= skip_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			win_q  <= win_d;
			kept_q <= kept_d;
		end
	end

	`IHSP_ASSERT_IMP(a_skip_nonzero, clk, arst_n, phase_q == PH_SKIP, skip_q != '0)
	`IHSP_ASSERT_IMP(a_fill_in_range, clk, arst_n, phase_q == PH_FILL, fill_q < WIN_FULL)
	`IHSP_ASSERT_NXT(a_last_restarts, clk, arst_n, step && last, phase_q == PH_INIT)

endmodule

// ===== rtl/core/ihsp_fmt_decode.sv =====
// Format decision and size selection from the header summary and the kept JPEG window.
module ihsp_fmt_decode (
	input  ihsp_pkg::hdr_info_t info,
	input  ihsp_pkg::win_t      kept,
	output logic [1:0]          image_format,
	output logic [31:0]         image_width,
	output logic [31:0]         image_height
);

	always_comb begin
		image_format = ihsp_pkg::FMT_UNKNOWN;
		image_width  = '0;
		image_height = '0;
		priority if (!info.full) begin
			image_format = ihsp_pkg::FMT_UNKNOWN;
		end else if (info.soi && kept[0] == ihsp_pkg::BYTE_FF) begin
			image_format = ihsp_pkg::FMT_JPEG;
			image_height = {16'd0, kept[5], kept[6]};
			image_width  = {16'd0, kept[7], kept[8]};
		end else if (info.gif) begin
			image_format = ihsp_pkg::FMT_GIF;
			image_width  = info.gif_width;
			image_height = info.gif_height;
		end else if (info.png) begin
			image_format = ihsp_pkg::FMT_PNG;
			image_width  = info.png_width;
			image_height = info.png_height;
		end else begin
			image_format = ihsp_pkg::FMT_UNKNOWN;
		end
	end

endmodule

// ===== rtl/core/image_header_size_parser.sv =====
// Top level of the image header size parser: input register, parse logic and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_ready  | data_byte[7:0], last_byte
//  output   | out_valid / out_ready| image_format[1:0], image_width[31:0],
//           |                      | image_height[31:0]
//
// One input transaction is taken per clock cycle while in_ready is high. A byte is first
// captured in the input register, and when it advances the header store, the segment walker
// and the format decode all update from it in a single combinational pass. Only a byte marked
// last creates a result: the result register and out_valid are loaded as that byte advances.
// Reset clears the byte counter, the walker phase and the valid flags; the byte stores are
// not reset because every read follows a write. While a result waits on out_ready, ordinary
// bytes of the next file keep flowing; only the next last byte waits in the input register.
`include "image_header_size_parser_macros.svh"

module image_header_size_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  image_format,
	output logic [31:0] image_width,
	output logic [31:0] image_height
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// The byte in the input register is processed this cycle when it is not a last byte,
	// or when the result register is free or being emptied.
	logic adv;

	logic [4:0]          idx;
	ihsp_pkg::hdr_info_t info;
	ihsp_pkg::win_t      kept;
	logic [1:0]          fmt_c;
	logic [31:0]         width_c;
	logic [31:0]         height_c;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  fmt_q;
	logic [31:0] width_q;
	logic [31:0] height_q;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ihsp_hdr_store u_hdr (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.last   (last_s1),
		.data   (byte_s1),
		.idx    (idx),
		.info   (info)
	);

	ihsp_seg_walker u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.last   (last_s1),
		.data   (byte_s1),
		.idx    (idx),
		.jfif   (info.jfif),
		.kept   (kept)
	);

	ihsp_fmt_decode u_dec (
		.info         (info),
		.kept         (kept),
		.image_format (fmt_c),
		.image_width  (width_c),
		.image_height (height_c)
	);

	// A new result is loaded only on a last byte; otherwise the valid flag drops once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			fmt_q    <= fmt_c;
			width_q  <= width_c;
			height_q <= height_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign image_format = fmt_q;
	assign image_width  = width_q;
	assign image_height = height_q;

	`IHSP_ASSERT_NXT(a_last_gives_result, clk, arst_n, adv && last_s1, out_valid_q)
	`IHSP_ASSERT_NXT(a_stage_holds, clk, arst_n, valid_s1 && !adv,
		valid_s1 && $stable(byte_s1) && $stable(last_s1))
	`IHSP_ASSERT_IMP(a_unknown_zero, clk, arst_n,
		out_valid_q && fmt_q == ihsp_pkg::FMT_UNKNOWN, width_q == '0 && height_q == '0)

endmodule
